@@ hw/rtl/rcst_pkg.sv @@
// Shared types and codes of the reference-counted slot table.
// No dependencies; imported by the top level, its port checker and the test files.
package rcst_pkg;

    // Operation codes; codes five to seven are unused and rejected.
    typedef logic [2:0] action_t;
    localparam action_t ACT_FIND  = 3'd0;
    localparam action_t ACT_ADD   = 3'd1;
    localparam action_t ACT_INC   = 3'd2;
    localparam action_t ACT_DEC   = 3'd3;
    localparam action_t ACT_CLEAR = 3'd4;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // One slot of the table as it lies in memory, kind in the lowest bits.
    typedef struct packed {
        logic [7:0]  count;
        logic [15:0] tag;
        logic [7:0]  kind;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Request transaction, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]  slot;
        logic [15:0] tag;
        logic [7:0]  kind;
        action_t     action;
    } request_t;

    localparam int REQ_W = $bits(request_t);

    // Result transaction, last field in the lowest bits.
    typedef struct packed {
        logic        released;
        logic [7:0]  count_after;
        logic [3:0]  slot_index;
        logic        status;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

@@ hw/rtl/rcst_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the slot storage of the table.
module rcst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/refcounted_slot_table_unit.sv @@
// Reference-counted slot table: a memory of SLOTS entries with kind, tag and count.
// Depends on rcst_pkg and rcst_ram.
//
// One request is worked on at a time. Find and add scan the slot memory through its
// single read port, one slot per cycle, and stop at the first hit or after the last
// slot (miss or full table). Increment and decrement read the addressed slot and
// write it back. Clear needs no memory sweep: every slot carries a valid flag in
// flip-flops, and an entry whose flag is low reads as all zero, so no sweep is
// needed after reset or clear. A result waits in the output register while the next
// request is already accepted.
module refcounted_slot_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], kind[10:3], tag[26:11], slot[30:27], zero[31]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[0], slot_index[4:1], count_after[12:5], released[13], zero[15:14]
    output logic [15:0] m_axis_tdata
);

    import rcst_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_MOD  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    request_t          req_reg, req_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic              issue_done_reg, issue_done_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    result_t           res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg, m_data_next;

    request_t          in_req;
    logic [AW-1:0]     in_addr;
    entry_t            ram_rdata;
    entry_t            entry_rd;
    entry_t            ram_wdata;
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic              hit;
    logic [7:0]        new_count;

    assign in_req   = request_t'(s_axis_tdata[REQ_W-1:0]);
    assign in_addr  = AW'(in_req.slot);
    // An entry whose valid flag is low reads as all zero.
    assign entry_rd = pend_vld_reg ? ram_rdata : entry_t'('0);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(16 - RES_W){1'b0}}, m_data_reg};

    rcst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pend_addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        rd_addr_next    = rd_addr_reg;
        issue_done_next = issue_done_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        pend_vld_next   = pend_vld_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_wdata       = entry_t'('0);
        ram_raddr       = rd_addr_reg;
        hit             = 1'b0;
        new_count       = entry_rd.count;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next = in_req;
                    res_next = '{status: 1'b1, default: '0};
                    case (in_req.action)
                        ACT_FIND, ACT_ADD:
                        begin
                            rd_addr_next    = '0;
                            issue_done_next = 1'b0;
                            pend_next       = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        ACT_INC, ACT_DEC:
                        begin
                            if (32'(in_req.slot) < 32'(SLOTS))
                            begin
                                ram_raddr      = in_addr;
                                pend_addr_next = in_addr;
                                pend_vld_next  = valid_reg[in_addr];
                                state_next     = ST_MOD;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            valid_next = '0;
                            res_next   = '0;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Reads run one slot ahead of the compare.
                if (!issue_done_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = rd_addr_reg;
                    pend_vld_next  = valid_reg[rd_addr_reg];
                    if (rd_addr_reg == LAST)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + AW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (req_reg.action == ACT_FIND)
                    begin
                        hit = (entry_rd.kind == req_reg.kind) && (entry_rd.tag == req_reg.tag);
                    end
                    else
                    begin
                        hit = (entry_rd.kind == 8'd0);
                    end

                    if (hit)
                    begin
                        res_next.status      = 1'b0;
                        res_next.slot_index  = 4'(pend_addr_reg);
                        res_next.count_after = entry_rd.count;
                        res_next.released    = 1'b0;
                        if (req_reg.action == ACT_ADD)
                        begin
                            ram_we                   = 1'b1;
                            ram_wdata.count          = entry_rd.count;
                            ram_wdata.tag            = req_reg.tag;
                            ram_wdata.kind           = req_reg.kind;
                            valid_next[pend_addr_reg] = 1'b1;
                        end
                        pend_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (pend_addr_reg == LAST)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_MOD:
            begin
                ram_we                    = 1'b1;
                valid_next[pend_addr_reg] = 1'b1;
                res_next.status           = 1'b0;
                res_next.slot_index       = 4'(pend_addr_reg);
                res_next.released         = 1'b0;
                if (req_reg.action == ACT_INC)
                begin
                    new_count = (entry_rd.count == COUNT_MAX) ? entry_rd.count
                                                              : entry_rd.count + 8'd1;
                    ram_wdata.count = new_count;
                    ram_wdata.tag   = entry_rd.tag;
                    ram_wdata.kind  = entry_rd.kind;
                end
                else
                begin
                    new_count = (entry_rd.count != 8'd0) ? entry_rd.count - 8'd1 : 8'd0;
                    if (new_count == 8'd0)
                    begin
                        // The slot is released: kind, tag and count all go to zero.
                        ram_wdata         = entry_t'('0);
                        res_next.released = 1'b1;
                    end
                    else
                    begin
                        ram_wdata.count = new_count;
                        ram_wdata.tag   = entry_rd.tag;
                        ram_wdata.kind  = entry_rd.kind;
                    end
                end
                res_next.count_after = new_count;
                state_next           = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_addr_reg    <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_addr_reg    <= rd_addr_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        pend_addr_reg <= pend_addr_next;
        pend_vld_reg  <= pend_vld_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

endmodule

@@ hw/rtl/rcst_checker.sv @@
// Port-level checks of the reference-counted slot table result stream.
// Depends on rcst_pkg; bound to refcounted_slot_table_unit below.
module rcst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    import rcst_pkg::*;

    result_t res;

    assign res = result_t'(m_axis_tdata[RES_W-1:0]);

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // Padding bits above the result fields are zero.
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:RES_W] == '0)
        else $error("padding bits of the result are not zero");

    // A failed request reports nothing but the failure.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.status |->
            res.slot_index == 4'd0 && res.count_after == 8'd0 && !res.released)
        else $error("failed request carries a slot, count or release");

    // A released slot is a successful decrement down to a zero count.
    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.released |-> !res.status && res.count_after == 8'd0)
        else $error("release reported with a nonzero count or a failure");

endmodule

bind refcounted_slot_table_unit rcst_checker u_rcst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/slot_table_monitor.sv @@
// Checker for the reference-counted slot table: predicts every result from the
// accepted requests and compares it field by field. Depends on rcst_pkg.
`timescale 1ns / 100ps

module slot_table_monitor #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // action[2:0], kind[10:3], tag[26:11], slot[30:27], zero[31]
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[0], slot_index[4:1], count_after[12:5], released[13], zero[15:14]
    input  logic [15:0] m_axis_tdata,
    output int          results_owed,
    output int          bad_fields
);

    import rcst_pkg::*;

    localparam int PRINT_CAP = 20;

    logic [7:0]  kind_tab [SLOTS];
    logic [15:0] tag_tab  [SLOTS];
    logic [7:0]  cnt_tab  [SLOTS];

    result_t owed_q[$];
    int      result_no;

    function automatic void wipe_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            kind_tab[i] = '0;
            tag_tab[i]  = '0;
            cnt_tab[i]  = '0;
        end
    endfunction

    // Applies one request to the shadow table and returns the result it must give.
    function automatic result_t apply_table_op(request_t req);
        result_t res;
        bit      hit;
        int      s;
        res        = '0;
        res.status = 1'b1;
        hit        = 1'b0;
        s          = int'(req.slot);
        case (req.action)
            ACT_FIND:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!hit && kind_tab[i] == req.kind && tag_tab[i] == req.tag)
                    begin
                        hit             = 1'b1;
                        res.status      = 1'b0;
                        res.slot_index  = 4'(i);
                        res.count_after = cnt_tab[i];
                    end
                end
            end
            ACT_ADD:
            begin
                // The count of a claimed slot is kept, not reset.
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!hit && kind_tab[i] == '0)
                    begin
                        hit             = 1'b1;
                        kind_tab[i]     = req.kind;
                        tag_tab[i]      = req.tag;
                        res.status      = 1'b0;
                        res.slot_index  = 4'(i);
                        res.count_after = cnt_tab[i];
                    end
                end
            end
            ACT_INC:
            begin
                if (s < SLOTS)
                begin
                    if (cnt_tab[s] != COUNT_MAX)
                        cnt_tab[s] = cnt_tab[s] + 8'd1;
                    res.status      = 1'b0;
                    res.slot_index  = 4'(s);
                    res.count_after = cnt_tab[s];
                end
            end
            ACT_DEC:
            begin
                if (s < SLOTS)
                begin
                    if (cnt_tab[s] != '0)
                        cnt_tab[s] = cnt_tab[s] - 8'd1;
                    // A count that ends at zero frees the slot, even if it was zero already.
                    if (cnt_tab[s] == '0)
                    begin
                        kind_tab[s]  = '0;
                        tag_tab[s]   = '0;
                        res.released = 1'b1;
                    end
                    res.status      = 1'b0;
                    res.slot_index  = 4'(s);
                    res.count_after = cnt_tab[s];
                end
            end
            ACT_CLEAR:
            begin
                wipe_table();
                res.status = 1'b0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        bad_fields++;
        if (bad_fields <= PRINT_CAP)
            $display("Mismatch on result %0d: %s is %0h, expected %0h", result_no, what,
                     got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t  got;
        result_t  want;
        request_t req;
        if (!rst_n)
        begin
            wipe_table();
            owed_q.delete();
            result_no = 0;
            bad_fields = 0;
            results_owed <= 0;
        end
        else
        begin
            // The result side goes first: a result always belongs to an earlier request.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[RES_W-1:0]);
                if (owed_q.size() == 0)
                    report_mismatch("transaction with no request waiting",
                                    32'(m_axis_tdata), 32'd0);
                else
                begin
                    want = owed_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.slot_index !== want.slot_index)
                        report_mismatch("slot_index", 32'(got.slot_index),
                                        32'(want.slot_index));
                    if (got.count_after !== want.count_after)
                        report_mismatch("count_after", 32'(got.count_after),
                                        32'(want.count_after));
                    if (got.released !== want.released)
                        report_mismatch("released", 32'(got.released), 32'(want.released));
                end
                result_no++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                req = request_t'(s_axis_tdata[REQ_W-1:0]);
                owed_q.push_back(apply_table_op(req));
            end
            results_owed <= owed_q.size();
        end
    end

endmodule

@@ test/tb.sv @@
// Testbench top for refcounted_slot_table_unit: drives request transactions with random
// gaps and result stalls, and gives the verdict. Depends on rcst_pkg and slot_table_monitor.
`timescale 1ns / 100ps

module tb;

    import rcst_pkg::*;

    localparam int SLOTS      = 16;
    localparam int ITEMS      = 1400;
    localparam int CYCLE_CAP  = 400000;
    localparam int ACT_CODES  = 2 ** $bits(action_t);

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    int results_owed;
    int bad_fields;
    int cycles;
    int sent;
    int drains;
    int act_seen [ACT_CODES];
    bit tx_fast;
    bit rx_fast;

    logic [7:0]  pool_kind [8];
    logic [15:0] pool_tag  [8];

    refcounted_slot_table_unit #(
        .SLOTS(SLOTS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    slot_table_monitor #(
        .SLOTS(SLOTS)
    ) monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .results_owed  (results_owed),
        .bad_fields    (bad_fields)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Timed out with %0d results outstanding.", results_owed);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: stall for a random number of cycles before each transaction.
    initial
    begin : result_sink
        int hold;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rx_fast ? 0 : $urandom_range(0, 5);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            if ($urandom_range(0, 39) == 0)
                rx_fast = !rx_fast;
        end
    end

    task automatic send_req(input action_t a, input logic [7:0] k, input logic [15:0] t,
                            input logic [3:0] s);
        request_t req;
        int       gap;
        req.action = a;
        req.kind   = k;
        req.tag    = t;
        req.slot   = s;
        gap = tx_fast ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {1'b0, req};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        act_seen[a]++;
        sent++;
    endtask

    // Holds off new requests until every outstanding result has been taken.
    task automatic wait_all_done();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        drains++;
    endtask

    function automatic void refresh_pool(input int p);
        pool_kind[p] = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        pool_tag[p]  = 16'($urandom);
    endfunction

    // General traffic over a small set of kind and tag pairs, so that finds hit.
    task automatic run_mix(input int n);
        int r;
        int p;
        refresh_pool($urandom_range(0, 7));
        refresh_pool($urandom_range(0, 7));
        for (int j = 0; j < n; j++)
        begin
            r = $urandom_range(0, 99);
            p = $urandom_range(0, 7);
            if (r < 30)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_req(ACT_FIND, pool_kind[p], pool_tag[p], 4'($urandom));
                else
                    send_req(ACT_FIND, 8'($urandom), 16'($urandom), 4'($urandom));
            end
            else if (r < 55)
            begin
                if ($urandom_range(0, 6) != 0)
                    send_req(ACT_ADD, pool_kind[p], pool_tag[p], 4'($urandom));
                else
                    send_req(ACT_ADD, 8'($urandom), 16'($urandom), 4'($urandom));
            end
            else if (r < 75)
                send_req(ACT_INC, 8'($urandom), 16'($urandom), 4'($urandom));
            else if (r < 93)
                send_req(ACT_DEC, 8'($urandom), 16'($urandom), 4'($urandom));
            else if (r < 96)
                send_req(ACT_CLEAR, 8'($urandom), 16'($urandom), 4'($urandom));
            else
                send_req(action_t'($urandom_range(int'(ACT_CLEAR) + 1, ACT_CODES - 1)),
                         8'($urandom), 16'($urandom), 4'($urandom));
        end
    endtask

    // Clears the table, fills it past its end, looks entries up, counts slots up and down, claims again.
    task automatic run_fill();
        int p;
        send_req(ACT_CLEAR, 8'($urandom), 16'($urandom), 4'($urandom));
        for (int j = 0; j < SLOTS + $urandom_range(1, 3); j++)
        begin
            p = $urandom_range(0, 7);
            if ($urandom_range(0, 1) == 0)
                send_req(ACT_ADD, pool_kind[p], pool_tag[p], 4'($urandom));
            else
                send_req(ACT_ADD, 8'($urandom_range(1, 255)), 16'($urandom), 4'($urandom));
        end
        for (int j = 0; j < 8; j++)
        begin
            p = $urandom_range(0, 7);
            send_req(ACT_FIND, pool_kind[p], pool_tag[p], 4'($urandom));
            send_req(ACT_INC, 8'($urandom), 16'($urandom), 4'($urandom));
        end
        for (int j = 0; j < 6; j++)
            send_req(ACT_DEC, 8'($urandom), 16'($urandom), 4'($urandom));
        for (int j = 0; j < 4; j++)
        begin
            p = $urandom_range(0, 7);
            send_req(ACT_ADD, pool_kind[p], pool_tag[p], 4'($urandom));
        end
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n         = 1'b0;
        tx_fast       = 1'b0;
        rx_fast       = 1'b0;
        for (int p = 0; p < 8; p++)
            refresh_pool(p);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table lookups, extreme fields, free-slot rules, unused codes.
        send_req(ACT_FIND, 8'h00, 16'h0000, 4'h0);
        send_req(ACT_FIND, 8'hFF, 16'hFFFF, 4'hF);
        send_req(ACT_ADD, 8'hFF, 16'hFFFF, 4'hF);
        send_req(ACT_FIND, 8'hFF, 16'hFFFF, 4'h0);
        send_req(ACT_ADD, 8'h00, 16'h1234, 4'h0);
        send_req(ACT_FIND, 8'h00, 16'h1234, 4'h0);
        send_req(ACT_INC, 8'h00, 16'h0000, 4'h1);
        send_req(ACT_ADD, 8'h5A, 16'hA5A5, 4'h0);
        send_req(ACT_INC, 8'hFF, 16'hFFFF, 4'hF);
        send_req(ACT_DEC, 8'h00, 16'h0000, 4'hF);
        send_req(ACT_DEC, 8'h00, 16'h0000, 4'h2);
        send_req(ACT_INC, 8'h00, 16'h0000, 4'h0);
        send_req(ACT_INC, 8'h00, 16'h0000, 4'h0);
        send_req(ACT_DEC, 8'h00, 16'h0000, 4'h0);
        send_req(ACT_FIND, 8'hFF, 16'hFFFF, 4'h0);
        send_req(ACT_DEC, 8'h00, 16'h0000, 4'h0);
        send_req(ACT_FIND, 8'hFF, 16'hFFFF, 4'h0);
        for (int c = int'(ACT_CLEAR) + 1; c < ACT_CODES; c++)
            send_req(action_t'(c), 8'hFF, 16'hFFFF, 4'hF);
        send_req(ACT_CLEAR, 8'hFF, 16'hFFFF, 4'hF);
        send_req(ACT_FIND, 8'h00, 16'h0000, 4'h0);
        wait_all_done();

        // Drive one count up to its ceiling and past it, then back down a little.
        begin : saturate
            logic [3:0] s;
            s = 4'($urandom);
            tx_fast = 1'b1;
            send_req(ACT_ADD, pool_kind[0], pool_tag[0], 4'h0);
            for (int j = 0; j < 258; j++)
                send_req(ACT_INC, 8'($urandom), 16'($urandom), s);
            tx_fast = 1'b0;
            for (int j = 0; j < 3; j++)
                send_req(ACT_DEC, 8'($urandom), 16'($urandom), s);
        end

        while (sent < ITEMS)
        begin
            tx_fast = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                run_fill();
            else
                run_mix($urandom_range(20, 40));
            if ($urandom_range(0, 9) == 0)
                wait_all_done();
        end

        wait_all_done();
        repeat (SLOTS + 8) @(posedge clk);

        $display("Sent %0d requests: %0d find, %0d add, %0d increment, %0d decrement, %0d clear.",
                 sent, act_seen[ACT_FIND], act_seen[ACT_ADD], act_seen[ACT_INC],
                 act_seen[ACT_DEC], act_seen[ACT_CLEAR]);
        $display("Also %0d unused codes, full-table adds, a saturated count, %0d drains.",
                 sent - act_seen[ACT_FIND] - act_seen[ACT_ADD] - act_seen[ACT_INC]
                 - act_seen[ACT_DEC] - act_seen[ACT_CLEAR], drains);
        if (bad_fields == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
